// ===== sv/lpp_pkg.sv =====
// Shared types and constants of the lidar packet parser.
`default_nettype none
package lpp_pkg;

    localparam int PACKET_BYTES        = 22;
    localparam int READINGS_PER_PACKET = 4;
    localparam int Q_W                 = $clog2(READINGS_PER_PACKET);
    localparam int POS_W               = 5;
    localparam int ACC_W               = 26;
    localparam int ANGLE_W             = 11;
    localparam int CNT_W               = 32;
    localparam int LAST_WORD_POS       = PACKET_BYTES - 3;

    localparam logic [7:0]         START_BYTE  = 8'hFA;
    localparam logic [ANGLE_W-1:0] INDEX_BASE  = 11'd160;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 11'h7FF;
    localparam logic [ANGLE_W-1:0] ANGLE_WRAP  = 11'd359;
    localparam logic [1:0]         ADDR_ENABLE = 2'd0;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] s_lo;
        logic [7:0] s_hi;
    } raw_reading_t;

    typedef struct packed {
        logic                                  done;
        logic [7:0]                            index;
        raw_reading_t [READINGS_PER_PACKET-1:0] rd;
        logic [7:0]                            chk_lo;
        logic [7:0]                            chk_hi;
        logic [ACC_W-1:0]                      acc;
    } pkt_t;

    typedef struct packed {
        logic [13:0] distance;
        logic [15:0] qual;
        logic        inv;
        logic        warn;
    } reading_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]          angle0;
        reading_t [READINGS_PER_PACKET-1:0] rd;
        logic                               ooo0;
        logic                               rot;
        logic [CNT_W-1:0]                   err;
        logic [CNT_W-1:0]                   dis;
        logic [CNT_W-1:0]                   meas_base;
        logic [CNT_W-1:0]                   rot_total;
    } rec_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [13:0]               distance;
        logic [15:0]               qual;
        logic                      inv;
        logic                      warn;
        logic                      ooo;
        logic                      new_rot;
        logic                      last;
        logic [CNT_W-1:0]          errors;
        logic [CNT_W-1:0]          dis_total;
        logic [CNT_W-1:0]          meas_total;
        logic [CNT_W-1:0]          rot_total;
    } out_t;

endpackage
`default_nettype wire

// ===== sv/lidar_packet_parser.sv =====
// Top level of the lidar packet parser: APB register, collector, decoder, emitter.
//
//   channel   direction  handshake         payload
//   s_        in         s_valid/s_ready   s_rx_byte, one serial byte per request
//   m_        out        m_valid/m_ready   one reading per request (angle .. totals)
//   apb       in         psel/penable      enable register at address 0
//
// One byte is taken per cycle. A packet's four readings leave through the result register,
// one per cycle while m_ready is high, once the done flag and the record are registered.
// The final byte of a packet stalls while the previous packet's readings are
// still queued in the record slot. A bad checksum yields no readings.
// Reset is synchronous on aresetn; enable low clears counters and packet state.
`default_nettype none
module lidar_packet_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_rx_byte,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic signed [10:0] m_angle,
    output logic [13:0]       m_distance,
    output logic [15:0]       m_quality,
    output logic              m_invalid_flag,
    output logic              m_weak_flag,
    output logic              m_out_of_order,
    output logic              m_new_rotation,
    output logic              m_last_of_packet,
    output logic [31:0]       m_packet_errors,
    output logic [31:0]       m_out_of_order_total,
    output logic [31:0]       m_measurement_total,
    output logic [31:0]       m_rotation_total
);
    import lpp_pkg::*;

    logic   enable_reg;
    pkt_t   pkt;
    rec_t   rec;
    out_t   res;
    logic   rec_valid;
    logic   rec_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == ADDR_ENABLE)) begin
            enable_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ENABLE) ? {31'b0, enable_reg} : 32'b0;

    lpp_collector u_collector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable_reg),
        .s_valid   (s_valid),
        .s_rx_byte (s_rx_byte),
        .rec_busy  (rec_valid),
        .s_ready   (s_ready),
        .pkt       (pkt)
    );

    lpp_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable_reg),
        .pkt       (pkt),
        .rec_take  (rec_take),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    lpp_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec       (rec),
        .m_ready   (m_ready),
        .rec_take  (rec_take),
        .m_valid   (m_valid),
        .res       (res)
    );

    assign m_angle              = res.angle;
    assign m_distance           = res.distance;
    assign m_quality            = res.qual;
    assign m_invalid_flag       = res.inv;
    assign m_weak_flag          = res.warn;
    assign m_out_of_order       = res.ooo;
    assign m_new_rotation       = res.new_rot;
    assign m_last_of_packet     = res.last;
    assign m_packet_errors      = res.errors;
    assign m_out_of_order_total = res.dis_total;
    assign m_measurement_total  = res.meas_total;
    assign m_rotation_total     = res.rot_total;

endmodule
`default_nettype wire

// ===== sv/lpp_collector.sv =====
// Start-byte hunt, packet byte store and running checksum fold.
`default_nettype none
module lpp_collector (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         enable,
    input  wire logic         s_valid,
    input  wire logic [7:0]   s_rx_byte,
    input  wire logic         rec_busy,
    output logic              s_ready,
    output lpp_pkg::pkt_t     pkt
);
    import lpp_pkg::*;

    logic                     collecting_reg;
    logic [POS_W-1:0]         pos_reg;
    logic                     done_reg;
    logic [7:0]               store_reg [PACKET_BYTES];
    logic [7:0]               low_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic                     last_byte;
    logic                     take;
    logic                     start_hit;

    assign last_byte = collecting_reg && (pos_reg == POS_W'(PACKET_BYTES - 1));
    assign s_ready   = !(last_byte && (done_reg || rec_busy));
    assign take      = s_valid && s_ready && enable;
    assign start_hit = !collecting_reg && (s_rx_byte == START_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            pos_reg        <= '0;
            done_reg       <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!enable) begin
                collecting_reg <= 1'b0;
                pos_reg        <= '0;
            end else if (take) begin
                if (start_hit) begin
                    collecting_reg <= 1'b1;
                    pos_reg        <= POS_W'(1);
                end else if (last_byte) begin
                    collecting_reg <= 1'b0;
                    pos_reg        <= '0;
                    done_reg       <= 1'b1;
                end else if (collecting_reg) begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && (collecting_reg || start_hit)) begin
            low_reg <= s_rx_byte;
            if (start_hit) begin
                store_reg[0] <= s_rx_byte;
                acc_reg      <= '0;
            end else begin
                store_reg[pos_reg] <= s_rx_byte;
                if (pos_reg[0] && (pos_reg <= POS_W'(LAST_WORD_POS))) begin
                    acc_reg <= {acc_reg[ACC_W-2:0], 1'b0} + ACC_W'({s_rx_byte, low_reg});
                end
            end
        end
    end

    always_comb begin
        pkt.done   = done_reg;
        pkt.index  = store_reg[1];
        pkt.chk_lo = store_reg[PACKET_BYTES - 2];
        pkt.chk_hi = store_reg[PACKET_BYTES - 1];
        pkt.acc    = acc_reg;
        for (int q = 0; q < READINGS_PER_PACKET; q++) begin
            pkt.rd[q].lo   = store_reg[4 + 4 * q];
            pkt.rd[q].hi   = store_reg[5 + 4 * q];
            pkt.rd[q].s_lo = store_reg[6 + 4 * q];
            pkt.rd[q].s_hi = store_reg[7 + 4 * q];
        end
    end

`ifndef SYNTH
    a_stall_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> last_byte)
        else $error("input stalled away from the last packet byte");
`endif
endmodule
`default_nettype wire

// ===== sv/lpp_decoder.sv =====
// Checksum check, angle and order tracking, running counters and packet record.
`default_nettype none
module lpp_decoder (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          enable,
    input  wire lpp_pkg::pkt_t pkt,
    input  wire logic          rec_take,
    output logic               rec_valid,
    output lpp_pkg::rec_t      rec
);
    import lpp_pkg::*;

    logic                       rec_valid_reg;
    rec_t                       rec_reg;
    rec_t                       rec_next;
    logic signed [ANGLE_W-1:0]  prev_angle_reg;
    logic [CNT_W-1:0]           err_reg;
    logic [CNT_W-1:0]           dis_reg;
    logic [CNT_W-1:0]           meas_reg;
    logic [CNT_W-1:0]           rot_reg;
    logic [15:0]                sum16;
    logic                       chk_ok;
    logic [ANGLE_W-1:0]         idx_diff;
    logic signed [ANGLE_W-1:0]  start_angle;
    logic signed [ANGLE_W:0]    angle_diff;
    logic                       in_order;
    logic                       rot;
    logic                       flagged;

    assign sum16  = {1'b0, pkt.acc[14:0]} + {5'b0, pkt.acc[ACC_W-1:15]};
    assign chk_ok = (sum16[7:0] == pkt.chk_lo) && ({1'b0, sum16[14:8]} == pkt.chk_hi);

    assign idx_diff    = {3'b0, pkt.index} - INDEX_BASE;
    assign start_angle = {idx_diff[ANGLE_W-3:0], 2'b00};
    assign angle_diff  = {start_angle[ANGLE_W-1], start_angle}
                       - {prev_angle_reg[ANGLE_W-1], prev_angle_reg};
    assign in_order    = (angle_diff == 12'sd1)    || (angle_diff == 12'sd361)
                      || (angle_diff == 12'sd721)  || (angle_diff == -12'sd359)
                      || (angle_diff == -12'sd719);
    assign rot         = (start_angle == '0) && (prev_angle_reg == ANGLE_WRAP);

    always_comb begin
        flagged            = 1'b0;
        rec_next.angle0    = start_angle;
        rec_next.ooo0      = !in_order;
        rec_next.rot       = rot;
        rec_next.err       = err_reg;
        rec_next.dis       = dis_reg + CNT_W'(!in_order);
        rec_next.meas_base = meas_reg;
        rec_next.rot_total = rot_reg + CNT_W'(rot);
        for (int q = 0; q < READINGS_PER_PACKET; q++) begin
            flagged           = pkt.rd[q].hi[7] || pkt.rd[q].hi[6];
            rec_next.rd[q].inv      = pkt.rd[q].hi[7];
            rec_next.rd[q].warn     = pkt.rd[q].hi[6];
            rec_next.rd[q].distance = flagged ? 14'd0 : {pkt.rd[q].hi[5:0], pkt.rd[q].lo};
            rec_next.rd[q].qual     = flagged ? 16'd0 : {pkt.rd[q].s_hi, pkt.rd[q].s_lo};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || !enable) begin
            rec_valid_reg  <= 1'b0;
            prev_angle_reg <= ANGLE_RESET;
            err_reg        <= '0;
            dis_reg        <= '0;
            meas_reg       <= '0;
            rot_reg        <= '0;
        end else begin
            if (rec_take) begin
                rec_valid_reg <= 1'b0;
            end
            if (pkt.done) begin
                if (chk_ok) begin
                    rec_valid_reg  <= 1'b1;
                    prev_angle_reg <= start_angle + ANGLE_W'(READINGS_PER_PACKET - 1);
                    dis_reg        <= rec_next.dis;
                    meas_reg       <= meas_reg + CNT_W'(READINGS_PER_PACKET);
                    rot_reg        <= rec_next.rot_total;
                end else begin
                    err_reg <= err_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt.done && chk_ok) begin
            rec_reg <= rec_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

`ifndef SYNTH
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt.done |-> !rec_valid_reg)
        else $error("packet completed while the record slot was busy");
    a_err_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (enable && $past(enable) && $past(aresetn) && !$past(pkt.done))
            |-> err_reg == $past(err_reg))
        else $error("error count moved without a completed packet");
`endif
endmodule
`default_nettype wire

// ===== sv/lpp_emitter.sv =====
// Serializes the readings of a packet record into the result register.
`default_nettype none
module lpp_emitter (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rec_valid,
    input  wire lpp_pkg::rec_t rec,
    input  wire logic          m_ready,
    output logic               rec_take,
    output logic               m_valid,
    output lpp_pkg::out_t      res
);
    import lpp_pkg::*;

    logic             m_valid_reg;
    out_t             res_reg;
    logic [Q_W-1:0]   q_reg;
    logic             load;
    logic             q_last;

    assign load     = rec_valid && (!m_valid_reg || m_ready);
    assign q_last   = (q_reg == Q_W'(READINGS_PER_PACKET - 1));
    assign rec_take = load && q_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            q_reg       <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                q_reg       <= q_reg + Q_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg.angle      <= rec.angle0 + ANGLE_W'(q_reg);
            res_reg.distance   <= rec.rd[q_reg].distance;
            res_reg.qual       <= rec.rd[q_reg].qual;
            res_reg.inv        <= rec.rd[q_reg].inv;
            res_reg.warn       <= rec.rd[q_reg].warn;
            res_reg.ooo        <= (q_reg == '0) && rec.ooo0;
            res_reg.new_rot    <= rec.rot;
            res_reg.last       <= q_last;
            res_reg.errors     <= rec.err;
            res_reg.dis_total  <= rec.dis;
            res_reg.meas_total <= rec.meas_base + CNT_W'(q_reg) + CNT_W'(1);
            res_reg.rot_total  <= rec.rot_total;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

`ifndef SYNTH
    a_q_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_take |=> q_reg == '0)
        else $error("reading index did not wrap after the last reading");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_lidar_packet_parser.sv =====
// Testbench for lidar_packet_parser: drives framed lidar byte streams and checks every reading.
module tb_lidar_packet_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import lpp_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         MAX_SHOWN     = 200;
    localparam int         DEGREES       = 360;
    localparam logic [7:0] FLAG_INVALID  = 8'h80;
    localparam logic [7:0] FLAG_WEAK     = 8'h40;
    localparam logic [7:0] FIRST_INDEX   = 8'(INDEX_BASE);
    localparam logic [7:0] LAST_INDEX    = 8'hF9;

    typedef logic [7:0] byte_q_t[$];
    typedef logic [7:0] packet_t [PACKET_BYTES];

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      psel      = 1'b0;
    logic                      penable   = 1'b0;
    logic                      pwrite    = 1'b0;
    logic [1:0]                paddr     = '0;
    logic [31:0]               pwdata    = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_rx_byte = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic signed [ANGLE_W-1:0] m_angle;
    logic [13:0]               m_distance;
    logic [15:0]               m_quality;
    logic                      m_invalid_flag;
    logic                      m_weak_flag;
    logic                      m_out_of_order;
    logic                      m_new_rotation;
    logic                      m_last_of_packet;
    logic [31:0]               m_packet_errors;
    logic [31:0]               m_out_of_order_total;
    logic [31:0]               m_measurement_total;
    logic [31:0]               m_rotation_total;

    lidar_packet_parser dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_angle              (m_angle),
        .m_distance           (m_distance),
        .m_quality            (m_quality),
        .m_invalid_flag       (m_invalid_flag),
        .m_weak_flag          (m_weak_flag),
        .m_out_of_order       (m_out_of_order),
        .m_new_rotation       (m_new_rotation),
        .m_last_of_packet     (m_last_of_packet),
        .m_packet_errors      (m_packet_errors),
        .m_out_of_order_total (m_out_of_order_total),
        .m_measurement_total  (m_measurement_total),
        .m_rotation_total     (m_rotation_total)
    );

    bit          parser_enable;
    bit          collecting;
    int          byte_pos;
    packet_t     packet_bytes;
    int          prev_angle;
    logic [31:0] error_count;
    logic [31:0] disorder_count;
    logic [31:0] reading_count;
    logic [31:0] rotation_count;
    out_t        pending_readings[$];

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          hold_left          = 0;
    logic [7:0]  next_index         = FIRST_INDEX;
    int          mismatches         = 0;
    int          cycle_count        = 0;
    int          bytes_sent         = 0;
    int          readings_checked   = 0;
    int          bad_packets        = 0;
    int          rotations_seen     = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings still expected",
                     cycle_count, pending_readings.size());
            $display("FAIL lidar_packet_parser");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic void clear_parser_state();
        collecting     = 1'b0;
        byte_pos       = 0;
        prev_angle     = -1;
        error_count    = '0;
        disorder_count = '0;
        reading_count  = '0;
        rotation_count = '0;
    endfunction

    function automatic logic [14:0] fold_checksum(packet_t p);
        logic [31:0] acc;
        logic [14:0] sum;
        acc = '0;
        for (int i = 0; i < PACKET_BYTES - 2; i += 2)
            acc = (acc << 1) + {p[i + 1], p[i]};
        sum = 15'(acc[14:0] + acc[31:15]);
        return sum;
    endfunction

    function automatic void decode_packet_bytes();
        logic [14:0] sum;
        int          start_angle;
        int          angle;
        int          diff;
        bit          rotation;
        bit          flagged;
        logic [7:0]  lo, hi, s_lo, s_hi;
        out_t        r;
        sum = fold_checksum(packet_bytes);
        if (sum[7:0] != packet_bytes[PACKET_BYTES - 2] ||
            {1'b0, sum[14:8]} != packet_bytes[PACKET_BYTES - 1]) begin
            error_count++;
            bad_packets++;
            return;
        end
        start_angle = (int'(packet_bytes[1]) - int'(INDEX_BASE)) * 4;
        rotation    = (start_angle == 0) && (prev_angle == int'(ANGLE_WRAP));
        if (rotation)
            rotation_count++;
        for (int q = 0; q < READINGS_PER_PACKET; q++) begin
            lo      = packet_bytes[4 + 4 * q];
            hi      = packet_bytes[5 + 4 * q];
            s_lo    = packet_bytes[6 + 4 * q];
            s_hi    = packet_bytes[7 + 4 * q];
            flagged = (hi & (FLAG_INVALID | FLAG_WEAK)) != 0;
            angle   = start_angle + q;
            diff    = (angle - prev_angle) % DEGREES;
            if (diff < 0)
                diff += DEGREES;
            r.angle    = angle[ANGLE_W-1:0];
            r.distance = flagged ? 14'd0 : {hi[5:0], lo};
            r.qual     = flagged ? 16'd0 : {s_hi, s_lo};
            r.inv      = (hi & FLAG_INVALID) != 0;
            r.warn     = (hi & FLAG_WEAK) != 0;
            r.ooo      = diff != 1;
            if (r.ooo)
                disorder_count++;
            reading_count++;
            prev_angle   = angle;
            r.new_rot    = rotation;
            r.last       = q == READINGS_PER_PACKET - 1;
            r.errors     = error_count;
            r.dis_total  = disorder_count;
            r.meas_total = reading_count;
            r.rot_total  = rotation_count;
            pending_readings.push_back(r);
        end
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        if (!parser_enable)
            return;
        if (!collecting) begin
            if (b == START_BYTE) begin
                packet_bytes[0] = b;
                byte_pos        = 1;
                collecting      = 1'b1;
            end
            return;
        end
        packet_bytes[byte_pos] = b;
        byte_pos++;
        if (byte_pos < PACKET_BYTES)
            return;
        decode_packet_bytes();
        byte_pos   = 0;
        collecting = 1'b0;
    endfunction

    function automatic logic [31:0] reading_word(logic [7:0] flags, logic [13:0] dist_mm,
                                                 logic [15:0] qual);
        return {qual, flags | {2'b00, dist_mm[13:8]}, dist_mm[7:0]};
    endfunction

    function automatic logic [31:0] random_reading();
        return reading_word($urandom_range(0, 1) ? 8'h00 : {2'($urandom), 6'b0},
                            14'($urandom), 16'($urandom));
    endfunction

    function automatic byte_q_t make_packet(logic [7:0] index,
                                            logic [31:0] raw [READINGS_PER_PACKET],
                                            bit bad_sum);
        packet_t     p;
        logic [14:0] sum;
        byte_q_t     bytes;
        p[0] = START_BYTE;
        p[1] = index;
        p[2] = 8'($urandom);
        p[3] = 8'($urandom);
        for (int q = 0; q < READINGS_PER_PACKET; q++)
            {p[7 + 4 * q], p[6 + 4 * q], p[5 + 4 * q], p[4 + 4 * q]} = raw[q];
        sum = fold_checksum(p);
        if (bad_sum)
            sum ^= 15'($urandom_range(1, 32767));
        p[PACKET_BYTES - 2] = sum[7:0];
        p[PACKET_BYTES - 1] = {1'b0, sum[14:8]};
        foreach (p[i])
            bytes.push_back(p[i]);
        return bytes;
    endfunction

    // mostly a steady sweep, with jumps near the wrap, anywhere in the valid index range and to any byte value
    function automatic logic [7:0] next_random_index();
        int         pick;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            idx = next_index;
        else if (pick < 75)
            idx = 8'($urandom_range(LAST_INDEX - 3, LAST_INDEX));
        else if (pick < 90)
            idx = 8'($urandom_range(FIRST_INDEX, LAST_INDEX));
        else
            idx = 8'($urandom);
        next_index = (idx >= LAST_INDEX || idx < FIRST_INDEX) ? FIRST_INDEX : idx + 8'd1;
        return idx;
    endfunction

    task automatic push_byte(logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic push_bytes(byte_q_t bytes);
        foreach (bytes[i])
            push_byte(bytes[i]);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_ENABLE) begin
            parser_enable = data[0];
            if (!parser_enable)
                clear_parser_state();
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check_enable();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ENABLE;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("enable readback", prdata, {31'b0, parser_enable});
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reconfigure(logic [31:0] word);
        wait_drained();
        apb_write(ADDR_ENABLE, word);
        apb_check_enable();
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= $urandom_range(0, 99) >= receiver_stall_pct;
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("reading at angle %0d with none expected", m_angle));
            end else begin
                want = pending_readings.pop_front();
                check_field("angle", m_angle, want.angle);
                check_field("distance", m_distance, want.distance);
                check_field("quality", m_quality, want.qual);
                check_field("invalid_flag", m_invalid_flag, want.inv);
                check_field("weak_flag", m_weak_flag, want.warn);
                check_field("out_of_order", m_out_of_order, want.ooo);
                check_field("new_rotation", m_new_rotation, want.new_rot);
                check_field("last_of_packet", m_last_of_packet, want.last);
                check_field("packet_errors", m_packet_errors, want.errors);
                check_field("out_of_order_total", m_out_of_order_total, want.dis_total);
                check_field("measurement_total", m_measurement_total, want.meas_total);
                check_field("rotation_total", m_rotation_total, want.rot_total);
                readings_checked++;
                if (m_new_rotation && m_last_of_packet)
                    rotations_seen++;
            end
        end
    end

    task automatic run_disabled_input();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        push_bytes(make_packet(FIRST_INDEX, '{random_reading(), random_reading(),
                                              random_reading(), random_reading()}, 1'b0));
        reconfigure(32'h1);
    endtask

    task automatic run_directed_packets();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h55);
        push_bytes(make_packet(FIRST_INDEX,
            '{reading_word(8'h00, 14'h3FFF, 16'hFFFF),
              reading_word(FLAG_INVALID, 14'h3FFF, 16'hFFFF),
              reading_word(FLAG_WEAK, 14'h1234, 16'h8001),
              reading_word(FLAG_INVALID | FLAG_WEAK, 14'h3FFF, 16'hFFFF)}, 1'b0));
        push_bytes(make_packet(LAST_INDEX,
            '{reading_word(8'h00, 14'h0, 16'h0), reading_word(8'h00, 14'h1, 16'h1),
              random_reading(), random_reading()}, 1'b0));
        // wrap from 359 back to zero
        push_bytes(make_packet(FIRST_INDEX, '{random_reading(), random_reading(),
                                              random_reading(), random_reading()}, 1'b0));
        // start bytes carried as payload
        push_bytes(make_packet(START_BYTE,
            '{reading_word(FLAG_INVALID | FLAG_WEAK, {6'h3A, START_BYTE}, {2{START_BYTE}}),
              reading_word(8'h00, {6'h3A, START_BYTE}, {2{START_BYTE}}),
              random_reading(), random_reading()}, 1'b0));
        push_bytes(make_packet(8'h00, '{random_reading(), random_reading(),
                                        random_reading(), random_reading()}, 1'b0));
        push_bytes(make_packet(8'hFF, '{random_reading(), random_reading(),
                                        random_reading(), random_reading()}, 1'b0));
        push_bytes(make_packet(FIRST_INDEX + 8'd1, '{random_reading(), random_reading(),
                                                     random_reading(), random_reading()}, 1'b1));
        wait_drained();
    endtask

    task automatic run_enable_clear();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        push_byte(START_BYTE);
        repeat (9) push_byte(8'($urandom));
        reconfigure(32'h0);
        reconfigure(32'hFFFF_FFFF);
        push_bytes(make_packet(FIRST_INDEX, '{random_reading(), random_reading(),
                                              random_reading(), random_reading()}, 1'b0));
        wait_drained();
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct, int packets);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (packets) begin
            if ($urandom_range(0, 99) < 25)
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            push_bytes(make_packet(next_random_index(),
                                   '{random_reading(), random_reading(),
                                     random_reading(), random_reading()},
                                   $urandom_range(0, 99) < 12));
        end
        wait_drained();
    endtask

    task automatic run_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = HOLD_CYCLES;
        repeat (2)
            push_bytes(make_packet(next_random_index(),
                                   '{random_reading(), random_reading(),
                                     random_reading(), random_reading()}, 1'b0));
        wait_drained();
    endtask

    initial begin
        parser_enable = 1'b0;
        clear_parser_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        run_disabled_input();
        run_directed_packets();
        run_enable_clear();
        run_random_phase(0, 0, 1);
        run_random_phase(58, 0, 1);
        run_random_phase(0, 58, 1);
        reconfigure(32'h0);
        reconfigure(32'h1);
        run_random_phase(27, 27, 1);
        run_backpressure();
        $display("covered %0d serial bytes, %0d readings checked, %0d bad checksums, %0d turns",
                 bytes_sent, readings_checked, bad_packets, rotations_seen);
        $display("idling: none, sender 58%%, receiver 58%%, both 27%%, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("PASS lidar_packet_parser");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL lidar_packet_parser");
        end
        $finish;
    end

endmodule
